// ===== hw/rtl/rcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcd_pkg
// Types and constants shared by the relay channel decider.
// ----------------------------------------------------------------------------
`default_nettype none

package rcd_pkg;

	localparam int unsigned NUM_CH   = 4;
	localparam int unsigned NUM_LAMP = 3;
	localparam int unsigned HUMID_CH = 3;

	localparam logic [9:0] MS_PER_SECOND = 10'd1000;

	typedef enum logic [1:0] {
		CMD_UPDATE     = 2'd0,
		CMD_TOGGLE     = 2'd1,
		CMD_LAMPS_INV  = 2'd2,
		CMD_NOP        = 2'd3
	} rcd_cmd_t;

	typedef enum logic [2:0] {
		MODE_OFF        = 3'd0,
		MODE_ON         = 3'd1,
		MODE_SENSOR     = 3'd2,
		MODE_SCHED      = 3'd3,
		MODE_SENSOR_SCH = 3'd4,
		MODE_GLOBAL     = 3'd5
	} rcd_mode_t;

	typedef enum logic [2:0] {
		REG_CHANNEL_CONTROL = 3'd0,
		REG_LAMP_THRESH     = 3'd1,
		REG_LAMP_HYST       = 3'd2,
		REG_HUMID_THRESH    = 3'd3,
		REG_HUMID_HYST      = 3'd4,
		REG_CYCLE_WORK      = 3'd5,
		REG_CYCLE_IDLE      = 3'd6,
		REG_GLOBAL_THRESH   = 3'd7
	} rcd_reg_t;

	typedef struct packed {
		logic       use_sched;
		logic       use_cyclic;
		logic       use_sensor;
		logic [2:0] mode;
	} rcd_chctl_t;

	typedef struct packed {
		logic [24:0] channel_control;
		logic [47:0] lamp_thresholds;
		logic [47:0] lamp_hysteresis;
		logic [9:0]  humid_threshold;
		logic [9:0]  humid_hysteresis;
		logic [25:0] work_ms;
		logic [25:0] idle_ms;
		logic [31:0] global_thresholds;
	} rcd_cfg_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] light_level;
		logic [9:0]  humidity_level;
		logic [31:0] now_ms;
		logic [3:0]  schedule_flags;
		logic [1:0]  channel_index;
	} rcd_item_t;

	typedef struct packed {
		logic [3:0]  relay;
		logic        duty_on;
		logic [31:0] duty_last;
	} rcd_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rcd_upd_if.sv =====
// ----------------------------------------------------------------------------
// rcd_upd_if
// Update channel: command, sensor levels, time and schedule bits.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcd_upd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] light_level;
	logic [9:0]  humidity_level;
	logic [31:0] now_ms;
	logic [3:0]  schedule_flags;
	logic [1:0]  channel_index;

	modport source (
		output valid, command, light_level, humidity_level, now_ms,
			schedule_flags, channel_index,
		input  ready
	);
	modport sink (
		input  valid, command, light_level, humidity_level, now_ms,
			schedule_flags, channel_index,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/rcd_res_if.sv =====
// ----------------------------------------------------------------------------
// rcd_res_if
// Result channel: relay states and change mask.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcd_res_if;
	logic       valid;
	logic       ready;
	logic [3:0] relay_bits;
	logic [3:0] changed_bits;

	modport source (output valid, relay_bits, changed_bits, input ready);
	modport sink (input valid, relay_bits, changed_bits, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rcd_decide.sv =====
// ----------------------------------------------------------------------------
// rcd_decide
// Next relay state and duty timer state for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module rcd_decide (
	input  rcd_pkg::rcd_cfg_t   cfg,
	input  rcd_pkg::rcd_item_t  item,
	input  rcd_pkg::rcd_state_t cur,
	output rcd_pkg::rcd_state_t nxt
);

	rcd_pkg::rcd_chctl_t hum_ctl;
	logic [31:0] elapsed;
	logic [25:0] period;
	logic        flip;
	logic        duty_run;
	logic        duty_val;
	logic        have_sched;
	logic [3:0]  decided;

	assign hum_ctl    = rcd_pkg::rcd_chctl_t'(cfg.channel_control[6*rcd_pkg::HUMID_CH +: 6]);
	assign have_sched = cfg.channel_control[24];
	assign elapsed    = item.now_ms - cur.duty_last;
	assign period     = cur.duty_on ? cfg.work_ms : cfg.idle_ms;
	assign flip       = elapsed > {6'b0, period};
	assign duty_run   = (rcd_pkg::rcd_cmd_t'(item.command) == rcd_pkg::CMD_UPDATE)
		&& hum_ctl.use_cyclic;
	assign duty_val   = cur.duty_on ^ flip;

	always_comb begin
		rcd_pkg::rcd_chctl_t ctl;
		logic [16:0] value;
		logic [16:0] low;
		logic [16:0] hyst;
		logic [16:0] limit;
		logic [16:0] glob;
		logic        sensor;
		logic        sbit;
		logic        r;
		for (int ch = 0; ch < rcd_pkg::NUM_CH; ch++) begin
			ctl  = rcd_pkg::rcd_chctl_t'(cfg.channel_control[6*ch +: 6]);
			sbit = item.schedule_flags[ch];
			if (ch == rcd_pkg::HUMID_CH) begin
				value = {7'b0, item.humidity_level};
				low   = {7'b0, cfg.humid_threshold};
				hyst  = {7'b0, cfg.humid_hysteresis};
				glob  = {1'b0, cfg.global_thresholds[31:16]};
			end else begin
				value = {1'b0, item.light_level};
				low   = {1'b0, cfg.lamp_thresholds[16*ch +: 16]};
				hyst  = {1'b0, cfg.lamp_hysteresis[16*ch +: 16]};
				glob  = {1'b0, cfg.global_thresholds[15:0]};
			end
			limit  = cur.relay[ch] ? low + hyst : low;
			sensor = value < limit;
			if (ctl.use_sensor || ctl.use_cyclic || ctl.use_sched) begin
				r = 1'b1;
				if (ctl.use_cyclic && (ch == rcd_pkg::HUMID_CH))
					r = duty_val;
				if (ctl.use_sensor)
					r = r && sensor;
				if (ctl.use_sched && have_sched)
					r = r && sbit;
			end else begin
				case (ctl.mode)
					rcd_pkg::MODE_ON:         r = 1'b1;
					rcd_pkg::MODE_SENSOR:     r = sensor;
					rcd_pkg::MODE_SCHED:      r = have_sched && sbit;
					rcd_pkg::MODE_SENSOR_SCH: r = have_sched && sensor && sbit;
					rcd_pkg::MODE_GLOBAL:     r = value < glob;
					default:                  r = 1'b0;
				endcase
			end
			decided[ch] = r;
		end
	end

	always_comb begin
		nxt.duty_on   = cur.duty_on;
		nxt.duty_last = cur.duty_last;
		if (duty_run && flip) begin
			nxt.duty_on   = ~cur.duty_on;
			nxt.duty_last = item.now_ms;
		end
		unique case (rcd_pkg::rcd_cmd_t'(item.command))
			rcd_pkg::CMD_UPDATE:    nxt.relay = decided;
			rcd_pkg::CMD_TOGGLE:    nxt.relay = cur.relay ^ (4'b0001 << item.channel_index);
			rcd_pkg::CMD_LAMPS_INV: nxt.relay = {cur.relay[3], {3{~cur.relay[0]}}};
			default:                nxt.relay = cur.relay;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/relay_channel_decider.sv =====
// ----------------------------------------------------------------------------
// relay_channel_decider
// Decides three lamp relays and one humidifier relay from sensor updates,
// a humidifier duty timer, schedule bits, toggle and lamp-invert commands.
//
//   port   dir   kind        contents
//   upd    in    valid/ready command, light, humidity, time, schedule, index
//   res    out   valid/ready relay_bits, changed_bits
//   p*     in    APB         eight registers at byte address 8*i, 64-bit data
//
// One beat per cycle sustained while res.ready is high. An accepted beat is
// registered in the input stage; the decision, relay state and duty timer
// update happen as it moves into the result register, which drives res.valid.
// Reset clears the relays and the duty timer and loads register defaults.
// A stalled result holds the input stage; upd.ready stays high while the
// input stage is empty or moving.
// ----------------------------------------------------------------------------
`default_nettype none

module relay_channel_decider (
	input  wire logic        clk,
	input  wire logic        arst_n,
	rcd_upd_if.sink          upd,
	rcd_res_if.source        res,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready
);

	rcd_pkg::rcd_cfg_t   cfg_q;
	logic [15:0]         work_sec_q;
	logic [15:0]         idle_sec_q;
	rcd_pkg::rcd_state_t state_q;
	rcd_pkg::rcd_state_t state_nx;
	rcd_pkg::rcd_item_t  item_s1;
	logic                valid_s1;
	logic                advance;
	logic                out_valid_q;
	logic [3:0]          relay_out_q;
	logic [3:0]          changed_out_q;
	logic                wr_en;
	rcd_pkg::rcd_reg_t   reg_sel;

	// config port
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = rcd_pkg::rcd_reg_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_control   <= 25'h028A28A;
			cfg_q.lamp_thresholds   <= 48'h012C_012C_012C;
			cfg_q.lamp_hysteresis   <= 48'h0032_0032_0032;
			cfg_q.humid_threshold   <= 10'd600;
			cfg_q.humid_hysteresis  <= 10'd100;
			cfg_q.work_ms           <= 26'd30000;
			cfg_q.idle_ms           <= 26'd60000;
			cfg_q.global_thresholds <= 32'h0258_012C;
			work_sec_q              <= 16'd30;
			idle_sec_q              <= 16'd60;
		end else if (wr_en) begin
			unique case (reg_sel)
				rcd_pkg::REG_CHANNEL_CONTROL: cfg_q.channel_control  <= pwdata[24:0];
				rcd_pkg::REG_LAMP_THRESH:     cfg_q.lamp_thresholds  <= pwdata[47:0];
				rcd_pkg::REG_LAMP_HYST:       cfg_q.lamp_hysteresis  <= pwdata[47:0];
				rcd_pkg::REG_HUMID_THRESH:    cfg_q.humid_threshold  <= pwdata[9:0];
				rcd_pkg::REG_HUMID_HYST:      cfg_q.humid_hysteresis <= pwdata[9:0];
				rcd_pkg::REG_CYCLE_WORK: begin
					work_sec_q    <= pwdata[15:0];
					cfg_q.work_ms <= {10'b0, pwdata[15:0]}
						* {16'b0, rcd_pkg::MS_PER_SECOND};
				end
				rcd_pkg::REG_CYCLE_IDLE: begin
					idle_sec_q    <= pwdata[15:0];
					cfg_q.idle_ms <= {10'b0, pwdata[15:0]}
						* {16'b0, rcd_pkg::MS_PER_SECOND};
				end
				rcd_pkg::REG_GLOBAL_THRESH:   cfg_q.global_thresholds <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			rcd_pkg::REG_CHANNEL_CONTROL: prdata = {39'b0, cfg_q.channel_control};
			rcd_pkg::REG_LAMP_THRESH:     prdata = {16'b0, cfg_q.lamp_thresholds};
			rcd_pkg::REG_LAMP_HYST:       prdata = {16'b0, cfg_q.lamp_hysteresis};
			rcd_pkg::REG_HUMID_THRESH:    prdata = {54'b0, cfg_q.humid_threshold};
			rcd_pkg::REG_HUMID_HYST:      prdata = {54'b0, cfg_q.humid_hysteresis};
			rcd_pkg::REG_CYCLE_WORK:      prdata = {48'b0, work_sec_q};
			rcd_pkg::REG_CYCLE_IDLE:      prdata = {48'b0, idle_sec_q};
			rcd_pkg::REG_GLOBAL_THRESH:   prdata = {32'b0, cfg_q.global_thresholds};
			default:                      prdata = '0;
		endcase
	end

	// input stage
	assign advance   = valid_s1 && (!out_valid_q || res.ready);
	assign upd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (upd.ready) begin
			valid_s1 <= upd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (upd.ready && upd.valid) begin
			item_s1.command        <= upd.command;
			item_s1.light_level    <= upd.light_level;
			item_s1.humidity_level <= upd.humidity_level;
			item_s1.now_ms         <= upd.now_ms;
			item_s1.schedule_flags <= upd.schedule_flags;
			item_s1.channel_index  <= upd.channel_index;
		end
	end

	rcd_decide u_decide (
		.cfg  (cfg_q),
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nx)
	);

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				state_q <= state_nx;
			if (advance)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			relay_out_q   <= state_nx.relay;
			changed_out_q <= state_nx.relay ^ state_q.relay;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.relay_bits   = relay_out_q;
	assign res.changed_bits = changed_out_q;

	// checks
	a_relay_matches_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (out_valid_q && (relay_out_q == state_q.relay)))
		else $error("result relay bits differ from relay state");

	a_toggle_one_change: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (rcd_pkg::rcd_cmd_t'(item_s1.command) == rcd_pkg::CMD_TOGGLE))
		|=> ($countones(changed_out_q) == 1))
		else $error("toggle did not change exactly one relay");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res.ready) |-> !advance)
		else $error("held result overwritten");

	a_duty_only_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(state_q.duty_last) |->
		$past(advance && (rcd_pkg::rcd_cmd_t'(item_s1.command) == rcd_pkg::CMD_UPDATE)))
		else $error("duty timer moved outside an update");

endmodule

`default_nettype wire
